// ----- rtl/core/sha_pkg.sv -----
// SHA-256 core package: payload structs, constants, round helpers.
// No dependencies.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    // controller -> datapath commands
    typedef struct packed {
        logic       put;        // write one byte into the block
        logic [7:0] put_byte;
        logic       start;      // load working vars from chain
        logic       round;      // run one round
        logic [5:0] rnd;
        logic       fold;       // add working vars into chain
        logic       init;       // restore initial hash
    } t_dp_cmd;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] init_word(input logic [2:0] i);
        init_word = INIT_HASH[(7 - i) * 32 +: 32];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[t];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/core/sha_datapath.sv -----
// SHA-256 datapath: chain value, working vars, 16-word schedule window.
// Depends on sha_pkg. Driven by sha_ctrl commands.
module sha_datapath (
    input  logic             i_clk,
    input  sha_pkg::t_dp_cmd i_cmd,
    input  logic             i_rst_n,
    input  logic [2:0]       i_rd_idx,
    output logic [31:0]      o_rd_word
);
    import sha_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;

    logic [3:0]  t_lo, i15, i2, i7;
    logic [31:0] w_new, w_use, s0w, s1w, s1, ch, s0, maj, t1, t2;
    logic [4:0]  sh;

    assign t_lo = i_cmd.rnd[3:0];
    assign i15  = t_lo + 4'd1;
    assign i2   = t_lo + 4'd14;
    assign i7   = t_lo + 4'd9;
    assign s0w  = rotr(r_w[i15], 7) ^ rotr(r_w[i15], 18) ^ (r_w[i15] >> 3);
    assign s1w  = rotr(r_w[i2], 17) ^ rotr(r_w[i2], 19) ^ (r_w[i2] >> 10);
    assign w_new = r_w[t_lo] + s0w + r_w[i7] + s1w;
    assign w_use = (i_cmd.rnd[5:4] == 2'd0) ? r_w[t_lo] : w_new;
    assign s1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + s1 + ch + round_k(i_cmd.rnd) + w_use;
    assign s0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = s0 + maj;
    assign sh   = {~r_fill[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_w[r_fill[5:2]] <= (r_w[r_fill[5:2]] & ~(32'hff << sh))
                              | ({24'd0, i_cmd.put_byte} << sh);
        end
        if (i_cmd.round) begin
            r_w[t_lo] <= w_use;
        end
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_word(3'(i));
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (!i_rst_n || i_cmd.init) begin
            r_fill <= '0;
        end else if (i_cmd.put) begin
            r_fill <= r_fill + 6'd1;
        end
    end

    assign o_rd_word = r_h[i_rd_idx];
endmodule

// ----- rtl/core/sha_ctrl.sv -----
// SHA-256 controller: byte intake, padding sequencer, round counter, output.
// Depends on sha_pkg. Commands sha_datapath.
module sha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_word o_word,
    output sha_pkg::t_dp_cmd   o_cmd,
    output logic [2:0]         o_rd_idx,
    input  logic [31:0]        i_rd_word
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [60:0] r_len;
    logic [5:0]  r_fill, r_rnd;
    logic        r_fin;     // padding in progress
    logic        r_p80;     // 0x80 byte already written
    logic        r_lenp;    // length bytes being written
    logic [2:0]  r_lcnt, r_oidx;
    logic        r_ov;
    t_out_word   r_out;
    logic [63:0] bits;
    logic [7:0]  pad_b;
    logic        acc;

    assign bits  = {r_len, 3'b000};
    assign pad_b = r_lenp ? bits[(7 - r_lcnt) * 8 +: 8] : 8'h00;
    assign o_ready = (r_state == S_IDLE);
    assign acc   = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_word  = r_out;
    assign o_rd_idx = r_oidx;
    assign n_state = r_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.rnd = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.put = acc && i_word.has_data;
                o_cmd.put_byte = i_word.data_byte;
            end
            S_PAD: begin
                o_cmd.put = 1'b1;
                o_cmd.put_byte = r_p80 ? pad_b : PAD_BYTE;
            end
            S_COMP: o_cmd.round = 1'b1;
            S_FOLD: o_cmd.fold = 1'b1;
            S_OUT:  o_cmd.init = (r_oidx == 3'd7) && r_ov && i_ready;
            default: ;
        endcase
        o_cmd.start = o_cmd.put && (r_fill == 6'd63);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= '0; r_fill <= '0; r_rnd <= '0;
            r_fin <= 1'b0; r_p80 <= 1'b0; r_lenp <= 1'b0; r_lcnt <= '0;
            r_oidx <= '0; r_ov <= 1'b0;
        end else begin
            if (o_cmd.put) r_fill <= r_fill + 6'd1;
            unique case (n_state)
                S_IDLE: if (acc) begin
                    if (i_word.has_data) r_len <= r_len + 61'd1;
                    r_fin <= i_word.last_byte;
                    if (o_cmd.start) begin
                        r_state <= S_COMP; r_rnd <= '0;
                    end else if (i_word.last_byte) begin
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    // first pad cycle writes 0x80, r_p80 then selects zeros/length
                    if (!r_p80) r_p80 <= 1'b1;
                    if (r_lenp) r_lcnt <= r_lcnt + 3'd1;
                    if (r_fill + 6'd1 == LEN_OFFSET && !r_lenp) r_lenp <= 1'b1;
                    if (o_cmd.start) begin
                        r_state <= S_COMP; r_rnd <= '0;
                    end
                end
                S_COMP: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (r_lenp && r_lcnt == 3'd0) begin
                        r_state <= S_OUT; r_oidx <= '0; r_ov <= 1'b0;
                    end else if (r_fin) r_state <= S_PAD;
                    else r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_out <= '{i_rd_word, r_oidx, r_oidx == 3'd7};
                    end else if (i_ready) begin
                        r_ov <= 1'b0;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_IDLE; r_len <= '0; r_fill <= '0;
                            r_fin <= 1'b0; r_p80 <= 1'b0; r_lenp <= 1'b0;
                        end
                        r_oidx <= r_oidx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/sha256_hash_core_top.sv -----
// SHA-256 hash core, byte-serial input, eight 32-bit digest words out.
// Throughput: one byte per cycle while filling; input then stalls for each full
// block while the single shared round unit runs its rounds and the fold.
// Last byte: padding written byte by byte (up to two blocks), then digest words
// one by one, each held until taken. Reset (sync, active low) restores the initial hash.
module sha256_hash_core_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_word o_word
);
    import sha_pkg::*;

    t_dp_cmd     cmd;
    logic [2:0]  rd_idx;
    logic [31:0] rd_word;

    sha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word,
        .o_valid, .i_ready, .o_word,
        .o_cmd(cmd), .o_rd_idx(rd_idx), .i_rd_word(rd_word)
    );

    sha_datapath u_dp (
        .i_clk, .i_cmd(cmd), .i_rst_n, .i_rd_idx(rd_idx), .o_rd_word(rd_word)
    );
endmodule

// ----- test/tb_sha256_hash_core_top.sv -----
// Testbench for sha256_hash_core_top: byte stream in, eight digest words out.
// Depends on sha_pkg and the core RTL; directed table first, then random messages.
`timescale 1ns / 100ps

module tb_sha256_hash_core_top;
    import sha_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_word;

    sha256_hash_core_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    // 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    localparam int CYCLE_LIMIT = 1000000;

    // Round constants, first 32 bits of the fractional cube roots of the first primes.
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Predictor state: chaining value, block buffer, fill and message length.
    logic [31:0] chain   [8];
    logic [7:0]  blk     [64];
    int          fill;
    logic [60:0] msg_len;

    t_out_word   digest_q [$];
    int          n_fail;
    int          n_mismatch;
    int          cycles;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of blk into chain.
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, mj;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + K_TAB[t] + w[t];
            s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic absorb(logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
    endtask

    task automatic hash_reset();
        for (int i = 0; i < 8; i++)
            chain[i] = H_INIT[i];
        fill = 0;
        msg_len = '0;
    endtask

    // Feed one accepted word through the predictor; queue digest words on last_byte.
    task automatic predict_word(t_in_word wd);
        logic [63:0] bit_len;
        t_out_word   r;
        if (wd.has_data) begin
            absorb(wd.data_byte);
            msg_len = msg_len + 61'd1;
        end
        if (wd.last_byte) begin
            bit_len = {msg_len, 3'b000};
            absorb(PAD_BYTE);
            while (fill != 56)
                absorb(8'h00);
            for (int i = 7; i >= 0; i--)
                absorb(bit_len[i*8 +: 8]);
            for (int i = 0; i < 8; i++) begin
                r.digest_word = chain[i];
                r.word_index  = 3'(i);
                r.last_word   = (i == 7);
                digest_q.push_back(r);
            end
            hash_reset();
        end
    endtask

    // Directed table. Known H0 digest words typed in for the empty message and "abc".
    typedef struct {
        t_in_word    wd;
        bit          known;
        logic [31:0] h0;
    } t_row;

    t_row dir_tab [$];

    task automatic add_row(logic [7:0] b, bit hd, bit lb, bit kn = 0,
                           logic [31:0] h0 = '0);
        t_row r;
        r.wd.data_byte = b;
        r.wd.has_data  = hd;
        r.wd.last_byte = lb;
        r.known        = kn;
        r.h0           = h0;
        dir_tab.push_back(r);
    endtask

    // Stimulus source: messages built into a word queue.
    t_in_word stim_q [$];

    task automatic add_msg(int len, bit end_empty, bit idle_noise);
        t_in_word wd;
        for (int i = 0; i < len; i++) begin
            if (idle_noise && $urandom_range(0, 9) == 0) begin
                wd.data_byte = 8'($urandom);
                wd.has_data  = 1'b0;
                wd.last_byte = 1'b0;
                stim_q.push_back(wd);
            end
            wd.data_byte = 8'($urandom);
            wd.has_data  = 1'b1;
            wd.last_byte = (!end_empty && i == len - 1);
            stim_q.push_back(wd);
        end
        if (end_empty || len == 0) begin
            wd.data_byte = 8'($urandom);
            wd.has_data  = 1'b0;
            wd.last_byte = 1'b1;
            stim_q.push_back(wd);
        end
    endtask

    // Known h0 values checked on the first digest word of marked messages.
    logic [31:0] known_h0_q [$];
    bit          known_q    [$];

    // Sender: bursts with random gaps, inputs changed at falling edges.
    task automatic send_word(t_in_word wd);
        @(negedge i_clk);
        i_word  <= wd;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_word(wd);
    endtask

    task automatic send_all();
        int burst;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0)
                    @(negedge i_clk);
                burst = $urandom_range(1, 40);
            end
            send_word(stim_q.pop_front());
            burst--;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Receiver stall pattern: alternates free-running and stalling phases.
    int stall_phase;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                i_ready <= 1'b1;
            else if (stall_phase < 200)
                i_ready <= ($urandom_range(0, 3) != 0);
            else
                i_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    // Result checker at the rising edge.
    logic [31:0] exp_h0;
    bit          exp_known;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                n_fail++;
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected digest word %h idx %0d",
                             o_word.digest_word, o_word.word_index);
            end else begin
                t_out_word e;
                e = digest_q.pop_front();
                if (e.word_index == 3'd0 && known_q.size() > 0) begin
                    exp_known = known_q.pop_front();
                    exp_h0    = known_h0_q.pop_front();
                    if (exp_known && o_word.digest_word != exp_h0) begin
                        n_fail++;
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("known digest H0: exp %h got %h",
                                     exp_h0, o_word.digest_word);
                    end
                end
                if (o_word !== e) begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 e.digest_word, e.word_index, e.last_word,
                                 o_word.digest_word, o_word.word_index,
                                 o_word.last_word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_word    = '0;
        n_fail    = 0;
        n_mismatch = 0;
        cycles    = 0;
        hash_reset();

        // Directed: empty message, idle word, "abc", extremes, block boundaries.
        add_row(8'hff, 0, 1, 1, 32'he3b0c442);
        add_row(8'h00, 0, 0);
        add_row(8'h61, 1, 0);
        add_row(8'h62, 1, 0);
        add_row(8'h63, 1, 1, 1, 32'hba7816bf);
        add_row(8'h00, 1, 1);
        add_row(8'hff, 1, 0);
        add_row(8'h55, 0, 0);
        add_row(8'haa, 1, 0);
        add_row(8'h12, 0, 1);
        foreach (dir_tab[i])
            stim_q.push_back(dir_tab[i].wd);
        foreach (dir_tab[i])
            if (dir_tab[i].wd.last_byte) begin
                known_q.push_back(dir_tab[i].known);
                known_h0_q.push_back(dir_tab[i].h0);
            end
        // Padding edge lengths: 55 fits, 56 spills to an extra block, 64 exact.
        add_msg(55, 0, 0);
        add_msg(56, 0, 0);
        add_msg(64, 1, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_all();

        // Hold off until every digest word is back.
        while (digest_q.size() > 0)
            @(posedge i_clk);

        // Random messages, mostly short, a few spanning blocks.
        while (stim_q.size() < 230) begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 130)
                                              : $urandom_range(0, 20);
            add_msg(len, $urandom_range(0, 3) == 0, 1);
        end
        send_all();

        while (digest_q.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
